### rtl/ac3fs_pkg.sv
`timescale 1ns / 1ps
package ac3fs_pkg;
  localparam logic [7:0] SYNC_HI = 8'h0b;
  localparam logic [7:0] SYNC_LO = 8'h77;
  localparam logic [5:0] CODE_LIMIT = 6'd38;
  localparam logic [11:0] MAX_FRAME = 12'd3840;
  localparam logic [11:0] MIN_FRAME = 12'd7;

  function automatic logic [9:0] kbps_lookup(input logic [4:0] idx);
    logic [9:0] k;
    case (idx)
      5'd0: k = 10'd32;
      5'd1: k = 10'd40;
      5'd2: k = 10'd48;
      5'd3: k = 10'd56;
      5'd4: k = 10'd64;
      5'd5: k = 10'd80;
      5'd6: k = 10'd96;
      5'd7: k = 10'd112;
      5'd8: k = 10'd128;
      5'd9: k = 10'd160;
      5'd10: k = 10'd192;
      5'd11: k = 10'd224;
      5'd12: k = 10'd256;
      5'd13: k = 10'd320;
      5'd14: k = 10'd384;
      5'd15: k = 10'd448;
      5'd16: k = 10'd512;
      5'd17: k = 10'd576;
      5'd18: k = 10'd640;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  // frame words for 44.1 kHz: floor(320*kbps/147), tabulated per rate index
  function automatic logic [11:0] words_441(input logic [4:0] idx);
    logic [11:0] w;
    case (idx)
      5'd0: w = 12'd69;
      5'd1: w = 12'd87;
      5'd2: w = 12'd104;
      5'd3: w = 12'd121;
      5'd4: w = 12'd139;
      5'd5: w = 12'd174;
      5'd6: w = 12'd208;
      5'd7: w = 12'd243;
      5'd8: w = 12'd278;
      5'd9: w = 12'd348;
      5'd10: w = 12'd417;
      5'd11: w = 12'd487;
      5'd12: w = 12'd557;
      5'd13: w = 12'd696;
      5'd14: w = 12'd835;
      5'd15: w = 12'd975;
      5'd16: w = 12'd1114;
      5'd17: w = 12'd1253;
      5'd18: w = 12'd1393;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

  typedef struct packed {
    logic        ok;
    logic [11:0] len;
    logic [15:0] srate;
    logic [19:0] brate;
  } hdr_t;
endpackage

### rtl/ac3_frame_sync_search_top.sv
`timescale 1ns / 1ps
// byte search for a confirmed ac-3 frame start
// input stream: in_tdata[7:0] carries one byte per transfer, in_tlast marks
// the final byte. bytes are written into a byte store one per cycle; bytes
// past the store depth are dropped.
// after the final byte the block drops in_tready and scans positions 0 to
// SEARCH_LIMIT-8, reading the store one byte per cycle through its single
// read port: each position reads the sync word, then the header bytes, and
// a header that passes is confirmed by the sync word at the next frame start.
// when the scan ends, the result is offered.
// one result transfer follows on out_*; if out_tready is low the result is
// held and the next stream waits until it is taken.
// reset clears control state; the store content is not cleared.
module ac3_frame_sync_search_top #(
  parameter int STORE_DEPTH = 8192,
  parameter int SEARCH_LIMIT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // found, frame_offset, byte_swapped, srate_hz,
                                  // brate_bps, frame_bytes, zero pad
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam int PW = $clog2(SEARCH_LIMIT);
  localparam logic [2:0] S_LOAD = 3'd0, S_POS = 3'd1, S_RD = 3'd2, S_CONF = 3'd3,
                         S_NEXT = 3'd4, S_OUT = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0] k_r, k_nxt;
  logic [7:0] hb_r [8];
  logic sw_r, sw_nxt;
  logic [AW+1:0] raddr_w;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic we;
  logic [12:0] qpos;
  ac3fs_pkg::hdr_t hdr;
  logic [63:0] res_r, res_nxt;

  assign in_tready = (st_r == S_LOAD);
  assign we = in_tvalid && in_tready && (cnt_r < CW'(STORE_DEPTH));
  assign qpos = 13'(pos_r) + 13'(hdr.len);

  always_comb begin
    raddr_w = (AW+2)'(pos_r) + (AW+2)'(k_r);
    if (st_r == S_CONF) raddr_w = (AW+2)'(qpos) + (AW+2)'(k_r);
    raddr = raddr_w[AW-1:0];
  end

  ac3fs_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(in_tdata),
    .raddr(raddr), .rdata(rdata)
  );

  ac3fs_hdr u_hdr (
    .b2(sw_r ? hb_r[3] : hb_r[2]), .b4(sw_r ? hb_r[5] : hb_r[4]),
    .b5(sw_r ? hb_r[4] : hb_r[5]), .hdr(hdr)
  );

  // k_r counts issued reads; data for read k-1 arrives when k_r is k
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; pos_nxt = pos_r; k_nxt = k_r;
    sw_nxt = sw_r; res_nxt = res_r;
    case (st_r)
      S_LOAD: if (in_tvalid) begin
        if (cnt_r < CW'(STORE_DEPTH)) cnt_nxt = cnt_r + 1'b1;
        if (in_tlast) begin
          st_nxt = S_POS; pos_nxt = '0; k_nxt = '0; res_nxt = '0;
        end
      end
      S_POS: begin
        if ((CW+1)'(pos_r) + (CW+1)'(8) > (CW+1)'(cnt_r)) st_nxt = S_OUT;
        else begin st_nxt = S_RD; k_nxt = 4'd1; end
      end
      S_RD: begin
        if (k_r < 4'd8) k_nxt = k_r + 1'b1;
        if (k_r == 4'd2) begin
          if (hb_r[0] == ac3fs_pkg::SYNC_HI && rdata == ac3fs_pkg::SYNC_LO) sw_nxt = 1'b0;
          else if (hb_r[0] == ac3fs_pkg::SYNC_LO && rdata == ac3fs_pkg::SYNC_HI)
            sw_nxt = 1'b1;
          else st_nxt = S_NEXT;
        end
        if (k_r == 4'd8) k_nxt = 4'd9;
        if (k_r == 4'd9) begin
          if (!hdr.ok || (14'(qpos) + 14'd1 >= 14'(cnt_r))) st_nxt = S_NEXT;
          else begin st_nxt = S_CONF; k_nxt = 4'd0; end
        end
      end
      S_CONF: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 4'd1 && rdata != hb_r[0]) st_nxt = S_NEXT;
        if (k_r == 4'd2) begin
          if (rdata != hb_r[1]) st_nxt = S_NEXT;
          else begin
            st_nxt = S_OUT;
            res_nxt = {3'd0, hdr.len, hdr.brate, hdr.srate, sw_r, 11'(pos_r), 1'b1};
          end
        end
      end
      S_NEXT: begin
        k_nxt = '0;
        if (32'(pos_r) >= SEARCH_LIMIT - 8) st_nxt = S_OUT;
        else begin pos_nxt = pos_r + 1'b1; st_nxt = S_POS; end
      end
      S_OUT: if (out_tready) begin st_nxt = S_LOAD; cnt_nxt = '0; end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; pos_r <= '0; k_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt; k_r <= k_nxt;
    end
    sw_r <= sw_nxt;
    res_r <= res_nxt;
    if (st_r == S_RD && k_r >= 4'd1 && k_r <= 4'd8) hb_r[k_r[2:0] - 3'd1] <= rdata;
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = res_r;
endmodule

### rtl/ac3fs_ram.sv
`timescale 1ns / 1ps
module ac3fs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/ac3fs_hdr.sv
`timescale 1ns / 1ps
module ac3fs_hdr (
  input  logic [7:0]      b2,
  input  logic [7:0]      b4,
  input  logic [7:0]      b5,
  output ac3fs_pkg::hdr_t hdr
);
  logic [4:0] bsid;
  logic [1:0] half;
  logic [5:0] code;
  logic [9:0] kbps;
  logic [11:0] len;
  logic [19:0] kb1000;
  logic [15:0] sr;
  logic ok;
  always_comb begin
    bsid = b5[7:3];
    code = b4[5:0];
    half = (bsid == 5'd9) ? 2'd1 : (bsid == 5'd10) ? 2'd2 : (bsid == 5'd11) ? 2'd3 : 2'd0;
    kbps = ac3fs_pkg::kbps_lookup(code[5:1]);
    kb1000 = 20'({kbps, 10'd0}) - 20'({kbps, 4'd0}) - 20'({kbps, 3'd0});
    ok = (bsid <= 5'd16) && !(bsid > 5'd10 && b2 >= 8'hc0) &&
         (code < ac3fs_pkg::CODE_LIMIT);
    case (b4[7:6])
      2'd0: begin len = {kbps, 2'b00}; sr = 16'(48000 >> half); end
      2'd1: begin
        len = 12'({ac3fs_pkg::words_441(code[5:1]) + 12'(code[0]), 1'b0});
        sr = 16'(44100 >> half);
      end
      2'd2: begin len = 12'({kbps, 2'b00}) + 12'({kbps, 1'b0}); sr = 16'(32000 >> half); end
      default: begin len = 12'd0; sr = 16'd0; ok = 1'b0; end
    endcase
    if (len < ac3fs_pkg::MIN_FRAME || len > ac3fs_pkg::MAX_FRAME) ok = 1'b0;
    hdr.ok = ok;
    hdr.len = len;
    hdr.srate = sr;
    hdr.brate = kb1000 >> half;
  end
endmodule
